// ----- design/assert_macros.svh -----
// assert_macros.svh: assertion macros shared by the stack RTL.
// Uses the signals clock and reset of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SLS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition that must never be seen.
`define SLS_NEVER(label, cond, msg) \
   `SLS_ASSERT(label, !(cond), msg)

`endif

// ----- design/sls_pkg.sv -----
// sls_pkg: types, codes and sizes for the sortable LIFO stack.
// No dependencies; used by every module of the block.
`default_nettype none

package sls_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;
   localparam int MODE_W  = 3;
   localparam int STAT_W  = 2;
   localparam int ENTRY_W = 5;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SORT    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      word_type          value;
   } req_payload_type;

   typedef struct packed {
      word_type           result_value;
      logic [STAT_W-1:0]  status;
      logic [ENTRY_W-1:0] entry_count;
   } rsp_payload_type;

   // what each cell does this cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH,      // take left neighbor (cell 0 takes the request value)
      CELL_POP,       // take right neighbor
      CELL_LOAD_TOP,  // cell 0 takes the request value
      CELL_TAG_INIT,  // tag = own position
      CELL_SORT_VAL,  // compare-exchange on signed word
      CELL_SORT_TAG   // compare-exchange on position tag
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic             phase;
      logic [CNT_W-1:0] count;
   } cell_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_SORT
   } ctrl_state_type;

endpackage

`default_nettype wire

// ----- design/sls_cell.sv -----
// sls_cell: one stack entry with its position tag; shifts and compare-exchanges
// with its neighbors. Depends on sls_pkg.
`default_nettype none

module sls_cell
   import sls_pkg::*;
(
   input  wire logic             clock,
   input  wire cell_cmd_type     cmd,
   input  wire logic [IDX_W-1:0] cell_index,
   input  wire word_type         left_word,
   input  wire logic [IDX_W-1:0] left_tag,
   input  wire word_type         right_word,
   input  wire logic [IDX_W-1:0] right_tag,
   output word_type              word_out,
   output logic [IDX_W-1:0]      tag_out
);

   word_type         word_ff, word_in;
   logic [IDX_W-1:0] tag_ff, tag_in;
   logic             lo_member, hi_member;
   logic             less_right, less_left, by_tag;

   always_comb begin
      by_tag    = (cmd.op == CELL_SORT_TAG);
      // lower slot of an active pair: partner is to the right
      lo_member = (cell_index[0] == cmd.phase) &&
                  ((CNT_W'(cell_index) + CNT_W'(1)) < cmd.count);
      // upper slot of an active pair: partner is to the left
      hi_member = (cell_index[0] != cmd.phase) && (cell_index != '0) &&
                  (CNT_W'(cell_index) < cmd.count);
      less_right = by_tag ? (tag_ff < right_tag) : (word_ff < right_word);
      less_left  = by_tag ? (left_tag < tag_ff)  : (left_word < word_ff);

      word_in = word_ff;
      tag_in  = tag_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
         end
         CELL_PUSH: begin
            word_in = left_word;
            tag_in  = left_tag;
         end
         CELL_POP: begin
            word_in = right_word;
            tag_in  = right_tag;
         end
         CELL_LOAD_TOP: begin
            if (cell_index == '0) begin
               word_in = left_word;
            end
         end
         CELL_TAG_INIT: begin
            tag_in = cell_index;
         end
         CELL_SORT_VAL, CELL_SORT_TAG: begin
            // larger key moves toward cell 0 (top of stack)
            if (lo_member && less_right) begin
               word_in = right_word;
               tag_in  = right_tag;
            end else if (hi_member && less_left) begin
               word_in = left_word;
               tag_in  = left_tag;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      tag_ff  <= tag_in;
   end

   assign word_out = word_ff;
   assign tag_out  = tag_ff;

endmodule

`default_nettype wire

// ----- design/sls_ctrl.sv -----
// sls_ctrl: fill count, sort sequencer, request/response handshakes and the
// response register. Depends on sls_pkg.
`default_nettype none

module sls_ctrl
   import sls_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_data,
   input  wire word_type        top_word,
   output cell_cmd_type         cell_cmd
);

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] round_ff, round_in;
   logic             key_tag_ff, key_tag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;
   logic             accept, is_empty, is_full;
   word_type         res;
   logic [STAT_W-1:0] status;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         round_ff     <= '0;
         key_tag_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         round_ff     <= round_in;
         key_tag_ff   <= key_tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
      accept    = req_valid && req_ready;
      is_empty  = (count_ff == '0);
      is_full   = (count_ff == CNT_W'(DEPTH));

      state_in     = state_ff;
      count_in     = count_ff;
      round_in     = round_ff;
      key_tag_in   = key_tag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      res          = '0;
      status       = STAT_OK;

      cell_cmd.op    = CELL_HOLD;
      cell_cmd.phase = round_ff[0];
      cell_cmd.count = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.mode)
                  MODE_PUSH: begin
                     if (is_full) begin
                        status = STAT_FULL;
                     end else begin
                        cell_cmd.op = CELL_PUSH;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_POP: begin
                     if (is_empty) begin
                        status = STAT_EMPTY;
                     end else begin
                        res         = top_word;
                        cell_cmd.op = CELL_POP;
                        count_in    = count_ff - CNT_W'(1);
                     end
                  end
                  MODE_PEEK: begin
                     if (is_empty) begin
                        status = STAT_EMPTY;
                     end else begin
                        res = top_word;
                     end
                  end
                  MODE_REPLACE: begin
                     cell_cmd.op = CELL_LOAD_TOP;
                     if (is_empty) begin
                        status   = STAT_EMPTY;
                        count_in = CNT_W'(1);
                     end else begin
                        res = top_word;
                     end
                  end
                  MODE_SORT: begin
                     state_in   = ST_SORT;
                     round_in   = '0;
                     key_tag_in = 1'b0;
                  end
                  MODE_REVERSE: begin
                     cell_cmd.op = CELL_TAG_INIT;
                     state_in    = ST_SORT;
                     round_in    = '0;
                     key_tag_in  = 1'b1;
                  end
                  default: begin
                  end
               endcase
               if (state_in == ST_IDLE) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.result_value = res;
                  rsp_data_in.status       = status;
                  rsp_data_in.entry_count  = ENTRY_W'(count_in);
               end
            end
         end
         ST_SORT: begin
            cell_cmd.op = key_tag_ff ? CELL_SORT_TAG : CELL_SORT_VAL;
            round_in    = round_ff + IDX_W'(1);
            if (round_ff == IDX_W'(DEPTH - 1)) begin
               state_in                 = ST_IDLE;
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_value = '0;
               rsp_data_in.status       = STAT_OK;
               rsp_data_in.entry_count  = ENTRY_W'(count_ff);
            end
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- design/sortable_lifo_stack.sv -----
// Sortable LIFO stack: DEPTH signed 32-bit entries held in a row of cells with
// the top of stack in cell 0. For push, pop, peek, replace and unknown codes the
// request is accepted and its response is registered at the same edge, so the
// response is valid the next cycle, and a new request is taken every cycle as
// long as the response side keeps up. Sort and reverse are first accepted, then
// run DEPTH rounds of odd-even compare-exchange between neighboring cells,
// alternating pair parity each round; no request is taken during the rounds.
// Reverse is the same network run on a position tag loaded into every cell at
// accept. Every request yields exactly one response. Depends on sls_pkg,
// sls_ctrl, sls_cell and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module sortable_lifo_stack
   import sls_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_data
);

   cell_cmd_type     cell_cmd;
   // chain taps: index i is cell i output; extra slot is the bottom boundary
   word_type         word_chain [DEPTH+1];
   logic [IDX_W-1:0] tag_chain  [DEPTH+1];
   // terms for the checks below
   logic             sorting, push_when_full, full_reported;

   // control, fill count and response register
   sls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .top_word  (word_chain[0]),
      .cell_cmd  (cell_cmd)
   );

   // below the bottom cell there is nothing; a pop shifts in don't-care data
   assign word_chain[DEPTH] = '0;
   assign tag_chain[DEPTH]  = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type         left_word;
      logic [IDX_W-1:0] left_tag;

      if (i == 0) begin : g_top
         // cell 0 takes the request value on push and replace
         assign left_word = req_data.value;
         assign left_tag  = '0;
      end else begin : g_mid
         assign left_word = word_chain[i-1];
         assign left_tag  = tag_chain[i-1];
      end

      sls_cell u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .cell_index (IDX_W'(i)),
         .left_word  (left_word),
         .left_tag   (left_tag),
         .right_word (word_chain[i+1]),
         .right_tag  (tag_chain[i+1]),
         .word_out   (word_chain[i]),
         .tag_out    (tag_chain[i])
      );
   end

   // ---- checks ----
   assign sorting        = (cell_cmd.op == CELL_SORT_VAL) || (cell_cmd.op == CELL_SORT_TAG);
   assign push_when_full = req_valid && req_ready && (req_data.mode == MODE_PUSH) &&
                           (cell_cmd.count == CNT_W'(DEPTH));
   assign full_reported  = rsp_valid && (rsp_data.status == STAT_FULL);

   `SLS_NEVER(a_count_bound, cell_cmd.count > CNT_W'(DEPTH), "fill count above depth")

   `SLS_NEVER(a_no_req_while_sorting, sorting && req_ready, "request taken during sort rounds")

   `SLS_ASSERT(a_sort_keeps_count, sorting |=> $stable(cell_cmd.count), "count moved in sort")

   `SLS_ASSERT(a_push_full, push_when_full |=> full_reported, "full push not reported")

endmodule

`default_nettype wire

// ----- bench/sortable_lifo_stack_checker.sv -----
// Checker for the sortable LIFO stack: watches both channels, keeps its own
// copy of the stack, and compares each response with the oldest prediction.
// Depends on sls_pkg for the payload types, sizes and codes.
module sortable_lifo_stack_checker
   import sls_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_ready,
   input  wire req_payload_type req_data,
   input  wire logic            rsp_valid,
   input  wire logic            rsp_ready,
   input  wire rsp_payload_type rsp_data,
   output int                   failures,
   output int                   pending
);

   // keep the log short when the block is badly broken
   localparam int REPORT_LIMIT = 100;

   word_type        stack_words [DEPTH];
   int unsigned     held;
   rsp_payload_type expected_rsps [$];
   int              fail_tally;

   // Applies one request to the local stack and returns its response.
   function automatic rsp_payload_type apply_request(input req_payload_type rq);
      rsp_payload_type r;
      word_type        key;
      word_type        swap;
      int              j;
      r.result_value = '0;
      r.status       = STAT_OK;
      case (rq.mode)
         MODE_PUSH: begin
            if (held < DEPTH) begin
               stack_words[held] = rq.value;
               held++;
            end else begin
               r.status = STAT_FULL;
            end
         end
         MODE_POP, MODE_PEEK, MODE_REPLACE: begin
            if (held == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.result_value = stack_words[held-1];
               if (rq.mode != MODE_PEEK)
                  held--;
            end
            // replace always leaves the new word on top, even when empty
            if (rq.mode == MODE_REPLACE) begin
               stack_words[held] = rq.value;
               held++;
            end
         end
         MODE_SORT: begin
            for (int i = 1; i < held; i++) begin
               key = stack_words[i];
               j = i;
               while (j > 0 && key < stack_words[j-1]) begin
                  stack_words[j] = stack_words[j-1];
                  j--;
               end
               stack_words[j] = key;
            end
         end
         MODE_REVERSE: begin
            for (int i = 0; i < held / 2; i++) begin
               swap                     = stack_words[i];
               stack_words[i]           = stack_words[held-1-i];
               stack_words[held-1-i]    = swap;
            end
         end
         default: ;
      endcase
      r.entry_count = ENTRY_W'(held);
      return r;
   endfunction

   task automatic flag(input string what, input logic [WORD_W-1:0] exp_v,
                       input logic [WORD_W-1:0] act_v);
      fail_tally++;
      if (fail_tally <= REPORT_LIMIT)
         $error("%s: expected %0d, actual %0d", what, $signed(exp_v), $signed(act_v));
   endtask

   always @(posedge clock) begin
      rsp_payload_type exp_rsp;
      if (reset) begin
         held       = 0;
         fail_tally = 0;
         expected_rsps.delete();
      end else begin
         if (req_valid && req_ready)
            expected_rsps.push_back(apply_request(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               fail_tally++;
               if (fail_tally <= REPORT_LIMIT)
                  $error("response with no request outstanding");
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_data.result_value !== exp_rsp.result_value)
                  flag("result_value", exp_rsp.result_value, rsp_data.result_value);
               if (rsp_data.status !== exp_rsp.status)
                  flag("status", WORD_W'(exp_rsp.status), WORD_W'(rsp_data.status));
               if (rsp_data.entry_count !== exp_rsp.entry_count)
                  flag("entry_count", WORD_W'(exp_rsp.entry_count),
                       WORD_W'(rsp_data.entry_count));
            end
         end
      end
      failures <= fail_tally;
      pending  <= expected_rsps.size();
   end

endmodule

// ----- bench/sortable_lifo_stack_test.sv -----
// Top of the sortable LIFO stack bench: clock, reset, request stimulus and
// response back-pressure, plus the final verdict.
// Depends on sls_pkg, sortable_lifo_stack and sortable_lifo_stack_checker.
module sortable_lifo_stack_test;
   import sls_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   // no handshake on either side for this long means the block is stuck;
   // the sort rounds and an 83% idle receiver stay far below this limit
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = DEPTH + 8;

   // codes with no operation behind them
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   req_payload_type req_data  = '0;
   logic            rsp_ready = 1'b0;
   logic            req_ready;
   logic            rsp_valid;
   rsp_payload_type rsp_data;

   int failures;
   int pending;
   int send_idle_pct = 22;
   int recv_idle_pct = 83;
   int quiet_cycles;

   always #5 clock = ~clock;

   sortable_lifo_stack DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   sortable_lifo_stack_checker CHECK (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   // Response side: ready drops at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: ends the run when neither channel moves for too long.
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   // Offers one request, with random idle cycles ahead of it, and returns at
   // the edge where it is taken. Valid stays high straight into the next
   // request when no idle cycle is drawn.
   task automatic send_request(input logic [MODE_W-1:0] mode, input word_type value);
      req_payload_type rq;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      rq.mode  = mode;
      rq.value = value;
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Words: extremes, small values (duplicates for sort), and full-range noise.
   function automatic word_type random_word();
      case ($urandom_range(9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         4, 5:    return $signed(32'($urandom_range(16))) - 32'sd8;
         default: return $urandom;
      endcase
   endfunction

   // Operation mix: filling runs mostly push so the stack reaches full,
   // draining runs mostly pop so it hits empty; sort/reverse appear in both.
   function automatic logic [MODE_W-1:0] pick_mode(input bit filling);
      int r;
      r = $urandom_range(99);
      if (filling) begin
         if (r < 55) return MODE_PUSH;
         if (r < 65) return MODE_POP;
         if (r < 73) return MODE_PEEK;
         if (r < 83) return MODE_REPLACE;
         if (r < 90) return MODE_SORT;
         if (r < 97) return MODE_REVERSE;
      end else begin
         if (r < 15) return MODE_PUSH;
         if (r < 55) return MODE_POP;
         if (r < 65) return MODE_PEEK;
         if (r < 77) return MODE_REPLACE;
         if (r < 86) return MODE_SORT;
         if (r < 95) return MODE_REVERSE;
      end
      return $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
   endfunction

   initial begin
      bit filling;
      int run_left;
      filling  = 1'b0;
      run_left = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty stack: every read flags empty, sort and reverse do nothing
      send_request(MODE_POP, random_word());
      send_request(MODE_PEEK, random_word());
      send_request(MODE_SORT, random_word());
      send_request(MODE_REVERSE, random_word());
      // replace on empty still leaves its word behind
      send_request(MODE_REPLACE, 32'sh7FFF_FFFF);
      // single entry: sort and reverse leave it alone
      send_request(MODE_SORT, random_word());
      send_request(MODE_REVERSE, random_word());
      // fill to the top with extreme and patterned words
      send_request(MODE_PUSH, 32'sh8000_0000);
      send_request(MODE_PUSH, '0);
      send_request(MODE_PUSH, -32'sd1);
      send_request(MODE_PUSH, 32'sd1);
      send_request(MODE_PUSH, 32'sh5555_5555);
      send_request(MODE_PUSH, 32'shAAAA_AAAA);
      repeat (DEPTH - 7)
         send_request(MODE_PUSH, random_word());
      // full: push is dropped, replace still swaps the top
      send_request(MODE_PUSH, random_word());
      send_request(MODE_REPLACE, random_word());
      send_request(MODE_SORT, random_word());
      send_request(MODE_REVERSE, random_word());
      send_request(MODE_PEEK, random_word());
      send_request(MODE_SPARE_HI, random_word());

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // swap which side idles a third of the way in, then stop idling
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 83;
            recv_idle_pct <= 22;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         if (run_left == 0) begin
            filling  = !filling;
            run_left = $urandom_range(20, 50);
         end
         run_left--;
         send_request(pick_mode(filling), random_word());
      end
      req_valid <= 1'b0;

      // the checker's count is registered, so it lags behind the last handshake
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+design
design/sls_pkg.sv
design/sls_cell.sv
design/sls_ctrl.sv
design/sortable_lifo_stack.sv
bench/sortable_lifo_stack_checker.sv
bench/sortable_lifo_stack_test.sv
